FILE: rtl/tsb_pkg.sv
// shared constants and types of the tile sprite blitter
package tsb_pkg;

  // default geometry
  localparam int unsigned ScreenWidthDef  = 320;
  localparam int unsigned ScreenHeightDef = 200;
  localparam int unsigned TileWidthDef    = 8;
  localparam int unsigned TileHeightDef   = 8;
  localparam int unsigned TilesDef        = 256;

  // writes per draw are capped here
  localparam int unsigned MaxResults = 64;
  localparam int unsigned CountW     = $clog2(MaxResults + 1);

  // field widths of the request and the frame-buffer write
  localparam int unsigned PosW    = 10;
  localparam int unsigned CoordW  = 11;  // position plus tile offset
  localparam int unsigned TileW   = 8;
  localparam int unsigned PalW    = 8;
  localparam int unsigned PixIdxW = 6;
  localparam int unsigned PixW    = 8;
  localparam int unsigned AddrW   = 16;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [0:0] {
    CMD_LOAD = 1'b0,
    CMD_DRAW = 1'b1
  } tsb_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_FLUSH
  } tsb_state_e;

endpackage

FILE: rtl/tile_sprite_blitter.sv
// tile sprite blitter top level: request decode, draw sequencer and write output
//
// The block holds TILES tiles of TILE_WIDTH x TILE_HEIGHT 8-bit palette-index
// pixels. A load request (tuser = 0) writes one tile pixel in the cycle it is
// accepted and produces no writes; loads can follow each other every cycle. A
// draw request (tuser = 1) walks the tile row by row, left to right (right to
// left within the row when mirrored), issuing one tile-store read per cycle
// while the output side does not stall; the tile store has a single read port.
// A draw runs through a setup state, the walk of TILE_WIDTH*TILE_HEIGHT pixels
// (64 at the defaults) and a flush of the held write. Each visible
// pixel becomes one frame-buffer write with address y*SCREEN_WIDTH+x (mod 2^16)
// and color pixel + 4*palette (mod 256); zero pixels are transparent and
// off-screen pixels are clipped. At most 64 writes are emitted per draw and the
// final one carries tlast. A draw of a tile number at or above TILES emits
// nothing. The store has no reset and needs no clearing: a pixel must be loaded
// before it is drawn. s_axis_tready is low while a draw is in progress.
module tile_sprite_blitter #(
  parameter int unsigned SCREEN_WIDTH  = tsb_pkg::ScreenWidthDef,
  parameter int unsigned SCREEN_HEIGHT = tsb_pkg::ScreenHeightDef,
  parameter int unsigned TILE_WIDTH    = tsb_pkg::TileWidthDef,
  parameter int unsigned TILE_HEIGHT   = tsb_pkg::TileHeightDef,
  parameter int unsigned TILES         = tsb_pkg::TilesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request channel
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // pos_x[9:0], pos_y[19:10], tile_number[27:20], palette_select[35:28],
  // mirror[36], pixel_index[42:37], pixel_value[50:43], zero fill[55:51]
  input  logic [tsb_pkg::InDataW-1:0]  s_axis_tdata,
  // cmd[0]
  input  logic                         s_axis_tuser,
  // frame-buffer write channel
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // fb_address[15:0], fb_color[23:16]
  output logic [tsb_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                         m_axis_tlast
);

  localparam int unsigned TilePixels = TILE_WIDTH * TILE_HEIGHT;
  localparam int unsigned StoreDepth = TILES * TilePixels;
  localparam int unsigned StoreAW    = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;
  localparam int unsigned ColW       = (TILE_WIDTH > 1) ? $clog2(TILE_WIDTH) : 1;
  localparam int unsigned RowW       = (TILE_HEIGHT > 1) ? $clog2(TILE_HEIGHT) : 1;
  localparam int unsigned CoordW     = tsb_pkg::CoordW;
  localparam int unsigned AddrW      = tsb_pkg::AddrW;
  localparam int unsigned PixW       = tsb_pkg::PixW;
  localparam int unsigned CountW     = tsb_pkg::CountW;

  // request field unpacking
  logic signed [tsb_pkg::PosW-1:0]    in_pos_x;
  logic signed [tsb_pkg::PosW-1:0]    in_pos_y;
  logic        [tsb_pkg::TileW-1:0]   in_tile;
  logic        [tsb_pkg::PalW-1:0]    in_pal;
  logic                               in_mirror;
  logic        [tsb_pkg::PixIdxW-1:0] in_pix_idx;
  logic        [PixW-1:0]             in_pix_val;

  assign in_pos_x   = s_axis_tdata[9:0];
  assign in_pos_y   = s_axis_tdata[19:10];
  assign in_tile    = s_axis_tdata[27:20];
  assign in_pal     = s_axis_tdata[35:28];
  assign in_mirror  = s_axis_tdata[36];
  assign in_pix_idx = s_axis_tdata[42:37];
  assign in_pix_val = s_axis_tdata[50:43];

  logic req_fire;
  logic tile_ok;
  logic load_we;
  logic [StoreAW-1:0] load_addr;

  assign req_fire  = s_axis_tvalid && s_axis_tready;
  assign tile_ok   = (32'(in_tile) < TILES);
  // load goes straight into the store, no state change
  assign load_we   = req_fire && (s_axis_tuser == tsb_pkg::CMD_LOAD) && tile_ok &&
                     (32'(in_pix_idx) < TilePixels);
  assign load_addr = StoreAW'(32'(in_tile) * TilePixels + 32'(in_pix_idx));

  // draw parameters captured at accept
  logic signed [tsb_pkg::PosW-1:0]  pos_x_q;
  logic signed [tsb_pkg::PosW-1:0]  pos_y_q;
  logic        [tsb_pkg::TileW-1:0] tile_q;
  logic        [tsb_pkg::PalW-1:0]  pal_q;
  logic                             mirror_q;

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      pos_x_q  <= in_pos_x;
      pos_y_q  <= in_pos_y;
      tile_q   <= in_tile;
      pal_q    <= in_pal;
      mirror_q <= in_mirror;
    end
  end

  // sequencer state
  tsb_pkg::tsb_state_e state_q, state_d;

  // walk counters (issue side)
  logic        [ColW-1:0]    col_q;
  logic        [RowW-1:0]    row_q;
  logic signed [CoordW-1:0]  px_q;
  logic signed [CoordW-1:0]  py_q;
  logic        [StoreAW-1:0] row_ptr_q;   // store index of the current row's first pixel
  logic        [AddrW-1:0]   row_addr_q;  // py*SCREEN_WIDTH, wraps mod 2^16
  logic                      issued_q;    // every pixel of the tile has been read

  // evaluate side: one pixel waiting on its store read
  logic               s1_valid_q;
  logic               s1_on_q;
  logic [AddrW-1:0]   s1_addr_q;
  logic               s1_end_q;

  // held-back write, so the final one can be marked
  logic               pend_valid_q;
  logic [AddrW-1:0]   pend_addr_q;
  logic [PixW-1:0]    pend_color_q;
  logic [CountW-1:0]  count_q;

  // output register
  logic               out_valid_q;
  logic [AddrW-1:0]   out_addr_q;
  logic [PixW-1:0]    out_color_q;
  logic               out_last_q;

  logic [PixW-1:0]    rd_pixel;

  // control decode
  logic out_free;
  logic visible;
  logic stall;
  logic advance;
  logic issue;
  logic take;
  logic flush_go;
  logic out_load;
  logic walk_end;
  logic col_end;
  logic row_end;

  assign out_free = !out_valid_q || m_axis_tready;
  assign col_end  = (col_q == ColW'(TILE_WIDTH - 1));
  assign row_end  = (row_q == RowW'(TILE_HEIGHT - 1));

  // next-state logic
  always_comb begin
    state_d = state_q;
    case (state_q)
      tsb_pkg::ST_IDLE: begin
        if (req_fire && (s_axis_tuser == tsb_pkg::CMD_DRAW) && tile_ok) begin
          state_d = tsb_pkg::ST_SETUP;
        end
      end
      tsb_pkg::ST_SETUP: begin
        state_d = tsb_pkg::ST_WALK;
      end
      tsb_pkg::ST_WALK: begin
        if (walk_end) begin
          state_d = tsb_pkg::ST_FLUSH;
        end
      end
      tsb_pkg::ST_FLUSH: begin
        if (!pend_valid_q || out_free) begin
          state_d = tsb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tsb_pkg::ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = (state_q == tsb_pkg::ST_IDLE);
    visible  = s1_valid_q && s1_on_q && (rd_pixel != '0) &&
               (count_q < CountW'(tsb_pkg::MaxResults));
    // a new write needs the held one moved out first
    stall    = visible && pend_valid_q && !out_free;
    advance  = (state_q == tsb_pkg::ST_WALK) && !stall;
    issue    = advance && !issued_q;
    take     = advance && visible;
    walk_end = advance && s1_valid_q && s1_end_q;
    flush_go = (state_q == tsb_pkg::ST_FLUSH) && pend_valid_q && out_free;
    out_load = (take && pend_valid_q) || flush_go;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // issue side: step through the tile, one store read per cycle unless stalled
  logic [ColW-1:0]    src_col;
  logic [StoreAW-1:0] rd_addr;
  logic               on_screen;
  logic [AddrW-1:0]   pix_addr;
  logic signed [tsb_pkg::PosW+12-1:0] y_prod;

  assign src_col   = mirror_q ? ColW'(TILE_WIDTH - 1) - col_q : col_q;
  assign rd_addr   = row_ptr_q + StoreAW'(src_col);
  assign on_screen = !px_q[CoordW-1] && !py_q[CoordW-1] &&
                     (32'(px_q) < SCREEN_WIDTH) && (32'(py_q) < SCREEN_HEIGHT);
  assign pix_addr  = row_addr_q + AddrW'(px_q);
  assign y_prod    = pos_y_q * $signed({1'b0, 11'(SCREEN_WIDTH)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      px_q       <= '0;
      py_q       <= '0;
      row_ptr_q  <= '0;
      row_addr_q <= '0;
      issued_q   <= 1'b0;
    end else if (state_q == tsb_pkg::ST_SETUP) begin
      col_q      <= '0;
      row_q      <= '0;
      px_q       <= CoordW'(pos_x_q);
      py_q       <= CoordW'(pos_y_q);
      row_ptr_q  <= StoreAW'(32'(tile_q) * TilePixels);
      row_addr_q <= AddrW'(y_prod);
      issued_q   <= 1'b0;
    end else if (issue) begin
      if (col_end) begin
        col_q      <= '0;
        row_q      <= row_q + 1'b1;
        px_q       <= CoordW'(pos_x_q);
        py_q       <= py_q + 1'b1;
        row_ptr_q  <= row_ptr_q + StoreAW'(TILE_WIDTH);
        row_addr_q <= row_addr_q + AddrW'(SCREEN_WIDTH);
        issued_q   <= row_end;
      end else begin
        col_q <= col_q + 1'b1;
        px_q  <= px_q + 1'b1;
      end
    end
  end

  // evaluate side control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_on_q    <= 1'b0;
      s1_end_q   <= 1'b0;
    end else if (issue) begin
      s1_valid_q <= 1'b1;
      s1_on_q    <= on_screen;
      s1_end_q   <= col_end && row_end;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_addr_q <= pix_addr;
    end
  end

  // held write and per-draw count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      count_q      <= '0;
    end else if (state_q == tsb_pkg::ST_SETUP) begin
      pend_valid_q <= 1'b0;
      count_q      <= '0;
    end else if (take) begin
      pend_valid_q <= 1'b1;
      count_q      <= count_q + 1'b1;
    end else if (flush_go) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      pend_addr_q  <= s1_addr_q;
      pend_color_q <= rd_pixel + {pal_q[PixW-3:0], 2'b00};
    end
  end

  // output register, parts the walk from the write channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_addr_q  <= pend_addr_q;
      out_color_q <= pend_color_q;
      out_last_q  <= flush_go;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_color_q, out_addr_q};
  assign m_axis_tlast  = out_last_q;

  tsb_tile_mem #(
    .Depth (StoreDepth),
    .AddrW (StoreAW)
  ) u_tile_mem (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (load_addr),
    .wdata_i (in_pix_val),
    .re_i    (issue),
    .raddr_i (rd_addr),
    .rdata_o (rd_pixel)
  );

  // the held write is always gone before a new request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsb_pkg::ST_IDLE) |-> !pend_valid_q)
    else $error("held write left over in idle");

  // write cap per draw
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(tsb_pkg::MaxResults))
    else $error("write count above cap");

  // never overwrite a write the channel has not taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output register overrun");

  // the pixel being evaluated belongs to a walk in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (state_q == tsb_pkg::ST_WALK))
    else $error("pixel in flight outside walk");

  // once every read is issued, the final pixel is still waiting in the walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == tsb_pkg::ST_WALK) && issued_q) |-> (s1_valid_q && s1_end_q))
    else $error("walk finished without its final pixel");

endmodule

FILE: rtl/tsb_tile_mem.sv
// tile pixel store: one write port, one registered read port
module tsb_tile_mem #(
  parameter int unsigned Depth = 16384,
  parameter int unsigned AddrW = 14
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AddrW-1:0]         waddr_i,
  input  logic [tsb_pkg::PixW-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AddrW-1:0]         raddr_i,
  output logic [tsb_pkg::PixW-1:0] rdata_o
);

  logic [tsb_pkg::PixW-1:0] mem_q [Depth];
  logic [tsb_pkg::PixW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
